// File: rtl/sip_pkg.sv
// Shared types, constants, round function and microcode store for the SipHash hasher.
package sip_pkg;

    localparam int W_WORD  = 64;
    localparam int W_COUNT = 4;
    localparam int W_BYTES = 3;
    localparam int W_TOTAL = 8;
    localparam int W_CFGIX = 3;

    localparam logic [W_WORD-1:0] SIP_C0 = 64'h736f6d6570736575;
    localparam logic [W_WORD-1:0] SIP_C1 = 64'h646f72616e646f6d;
    localparam logic [W_WORD-1:0] SIP_C2 = 64'h6c7967656e657261;
    localparam logic [W_WORD-1:0] SIP_C3 = 64'h7465646279746573;

    localparam logic [W_WORD-1:0] TWEAK_WIDE   = 64'h0000_0000_0000_00EE;
    localparam logic [W_WORD-1:0] TWEAK_NARROW = 64'h0000_0000_0000_00FF;
    localparam logic [W_WORD-1:0] TWEAK_HALF2  = 64'h0000_0000_0000_00DD;

    localparam int ROT_A = 13;
    localparam int ROT_B = 32;
    localparam int ROT_C = 16;
    localparam int ROT_D = 17;
    localparam int ROT_E = 21;

    localparam logic [W_COUNT-1:0] RESET_C_ROUNDS = 4'd2;
    localparam logic [W_COUNT-1:0] RESET_D_ROUNDS = 4'd4;

    // configuration register indexes
    typedef enum logic [W_CFGIX-1:0] {
        CFG_KEY_HIGH = 3'd0,
        CFG_KEY_LOW  = 3'd1,
        CFG_C_ROUNDS = 3'd2,
        CFG_D_ROUNDS = 3'd3,
        CFG_WIDE     = 3'd4
    } t_cfg_index;

    typedef logic [3:0][W_WORD-1:0] t_vstate;

    typedef struct packed {
        logic [W_WORD-1:0]  key_high;
        logic [W_WORD-1:0]  key_low;
        logic [W_COUNT-1:0] c_rounds;
        logic [W_COUNT-1:0] d_rounds;
        logic               wide;
    } t_cfg;

    // microcode fields
    typedef enum logic [1:0] {
        OP_WAIT  = 2'd0,
        OP_ROUND = 2'd1,
        OP_EMIT  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        EX_NONE   = 2'd0,
        EX_ABSORB = 2'd1,
        EX_FOLD0  = 2'd2,
        EX_FOLD1  = 2'd3
    } t_exit;

    typedef enum logic [1:0] {
        C_ALWAYS   = 2'd0,
        C_LAST     = 2'd1,
        C_WIDE     = 2'd2,
        C_OUT_FREE = 2'd3
    } t_cond;

    typedef enum logic [2:0] {
        P_IDLE    = 3'd0,
        P_CROUND  = 3'd1,
        P_FROUND0 = 3'd2,
        P_FROUND1 = 3'd3,
        P_EMIT    = 3'd4
    } t_step;

    typedef struct packed {
        t_op   op;
        t_exit exit_act;
        t_cond cond;
        t_step next_a;
        t_step next_b;
        logic  accept_ok;
    } t_uword;

    // sequencer -> datapath
    typedef struct packed {
        t_exit exit_act;
        logic  do_round;
        logic  loop_exit;
        logic  accept;
        logic  emit;
    } t_ctl;

    // datapath -> sequencer
    typedef struct packed {
        logic last;
        logic out_free;
    } t_dp_status;

    function automatic t_uword microcode(input t_step pc);
        t_uword w;
        begin
            unique case (pc)
                P_IDLE:    w = '{OP_WAIT,  EX_NONE,   C_ALWAYS,   P_IDLE,    P_IDLE,    1'b1};
                P_CROUND:  w = '{OP_ROUND, EX_ABSORB, C_LAST,     P_FROUND0, P_IDLE,    1'b1};
                P_FROUND0: w = '{OP_ROUND, EX_FOLD0,  C_WIDE,     P_FROUND1, P_EMIT,    1'b0};
                P_FROUND1: w = '{OP_ROUND, EX_FOLD1,  C_ALWAYS,   P_EMIT,    P_EMIT,    1'b0};
                P_EMIT:    w = '{OP_EMIT,  EX_NONE,   C_OUT_FREE, P_IDLE,    P_EMIT,    1'b0};
                default:   w = '{OP_WAIT,  EX_NONE,   C_ALWAYS,   P_IDLE,    P_IDLE,    1'b0};
            endcase
            return w;
        end
    endfunction

    function automatic logic [W_WORD-1:0] rotl(input logic [W_WORD-1:0] x, input int s);
        return (x << s) | (x >> (W_WORD - s));
    endfunction

    function automatic logic [W_WORD-1:0] bswap(input logic [W_WORD-1:0] x);
        logic [W_WORD-1:0] r;
        begin
            for (int i = 0; i < W_WORD / 8; i++) begin
                r[8*i +: 8] = x[8*(W_WORD/8-1-i) +: 8];
            end
            return r;
        end
    endfunction

    function automatic t_vstate sip_round(input t_vstate v);
        t_vstate r;
        begin
            r = v;
            r[0] = r[0] + r[1];
            r[1] = rotl(r[1], ROT_A) ^ r[0];
            r[0] = rotl(r[0], ROT_B);
            r[2] = r[2] + r[3];
            r[3] = rotl(r[3], ROT_C) ^ r[2];
            r[2] = r[2] + r[1];
            r[1] = rotl(r[1], ROT_D) ^ r[2];
            r[2] = rotl(r[2], ROT_B);
            r[0] = r[0] + r[3];
            r[3] = rotl(r[3], ROT_E) ^ r[0];
            return r;
        end
    endfunction

endpackage

// File: rtl/siphash_message_hasher_top.sv
// Top level of the keyed SipHash-c-d message hasher with its configuration registers.
// Compression: c = compression rounds, one SipRound per cycle in the shared round unit;
//   the next word is taken in the cycle its last round runs.
// The last word runs its compression rounds, then d finalization rounds (d more for a 128-bit
//   hash), then one emit step; the result shows the cycle after that.
// Reset (i_rst_n low, synchronous): sequencer back to idle, no message open, result
//   register empty, key zero, c = 2, d = 4, 64-bit output.
module siphash_message_hasher_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [sip_pkg::W_CFGIX-1:0]    i_cfg_index,
    input  logic [sip_pkg::W_WORD-1:0]     i_cfg_data,
    // input transactions
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [sip_pkg::W_WORD-1:0]     i_message_word,
    input  logic                           i_is_last,
    input  logic [sip_pkg::W_BYTES-1:0]    i_last_bytes,
    // result transactions
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [sip_pkg::W_WORD-1:0]     o_hash_low,
    output logic [sip_pkg::W_WORD-1:0]     o_hash_high
);
    import sip_pkg::*;

    // Configuration registers; the user must write them only while idle, which the block
    // does not enforce, as the datapath reads them directly. Indexes beyond the list are dropped.
    t_cfg       r_cfg;
    t_ctl       ctl;
    t_dp_status status;
    logic       in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_high <= '0;
            r_cfg.key_low  <= '0;
            r_cfg.c_rounds <= RESET_C_ROUNDS;
            r_cfg.d_rounds <= RESET_D_ROUNDS;
            r_cfg.wide     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEY_HIGH: r_cfg.key_high <= i_cfg_data;
                CFG_KEY_LOW:  r_cfg.key_low  <= i_cfg_data;
                CFG_C_ROUNDS: r_cfg.c_rounds <= i_cfg_data[W_COUNT-1:0];
                CFG_D_ROUNDS: r_cfg.d_rounds <= i_cfg_data[W_COUNT-1:0];
                CFG_WIDE:     r_cfg.wide     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer walks the microcode: idle -> compression loop -> first finalization
    // loop -> (128-bit only) second finalization loop -> emit. A word that is not last
    // lets the next transaction in on the final compression cycle.
    sip_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cfg      (r_cfg),
        .i_status   (status),
        .o_ctl      (ctl),
        .o_in_ready (in_ready)
    );

    // Datapath holds v0..v3, the padded word, the byte count and the result register;
    // the result register frees the sequencer from waiting on the consumer until the
    // next hash is ready to leave.
    sip_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_cfg          (r_cfg),
        .i_message_word (i_message_word),
        .i_is_last      (i_is_last),
        .i_last_bytes   (i_last_bytes),
        .i_out_stall    (i_out_stall),
        .o_status       (status),
        .o_out_valid    (o_out_valid),
        .o_hash_low     (o_hash_low),
        .o_hash_high    (o_hash_high)
    );

    assign o_in_stall = !in_ready;

endmodule

// File: rtl/sip_sequencer.sv
// Microcode sequencer: step counter, round counter and conditional jumps.
module sip_sequencer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  sip_pkg::t_cfg                  i_cfg,
    input  sip_pkg::t_dp_status            i_status,
    output sip_pkg::t_ctl                  o_ctl,
    output logic                           o_in_ready
);
    import sip_pkg::*;

    t_step              r_pc;
    t_step              n_pc;
    logic [W_COUNT-1:0] r_cnt;
    logic [W_COUNT-1:0] n_cnt;
    t_uword             uw;
    logic               loop_done;
    logic               loop_exit;
    logic               do_round;
    logic               accept;
    logic               take_a;
    logic               reload_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= P_IDLE;
            r_cnt <= '0;
        end else begin
            r_pc  <= n_pc;
            r_cnt <= n_cnt;
        end
    end

    always_comb begin
        uw        = microcode(r_pc);
        loop_done = (uw.op != OP_ROUND) || (r_cnt <= W_COUNT'(1));
        loop_exit = (uw.op == OP_ROUND) && loop_done;
        do_round  = (uw.op == OP_ROUND) && (r_cnt != '0);
        o_in_ready = uw.accept_ok && loop_done && !i_status.last;
        accept    = o_in_ready && i_in_valid;

        unique case (uw.cond)
            C_ALWAYS:   take_a = 1'b1;
            C_LAST:     take_a = i_status.last;
            C_WIDE:     take_a = i_cfg.wide;
            C_OUT_FREE: take_a = i_status.out_free;
            default:    take_a = 1'b1;
        endcase

        if (accept) begin
            n_pc = P_CROUND;
        end else if (!loop_done) begin
            n_pc = r_pc;
        end else begin
            n_pc = take_a ? uw.next_a : uw.next_b;
        end

        reload_d = loop_exit &&
                   (((uw.exit_act == EX_ABSORB) && i_status.last) ||
                    ((uw.exit_act == EX_FOLD0) && i_cfg.wide));
        if (accept) begin
            n_cnt = i_cfg.c_rounds;
        end else if (reload_d) begin
            n_cnt = i_cfg.d_rounds;
        end else if (do_round) begin
            n_cnt = r_cnt - W_COUNT'(1);
        end else begin
            n_cnt = r_cnt;
        end

        o_ctl.exit_act  = uw.exit_act;
        o_ctl.do_round  = do_round;
        o_ctl.loop_exit = loop_exit;
        o_ctl.accept    = accept;
        o_ctl.emit      = (uw.op == OP_EMIT) && i_status.out_free;
    end

endmodule

// File: rtl/sip_datapath.sv
// Datapath: mixing words, byte count, padded word, fold registers and result register.
module sip_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sip_pkg::t_ctl                  i_ctl,
    input  sip_pkg::t_cfg                  i_cfg,
    input  logic [sip_pkg::W_WORD-1:0]     i_message_word,
    input  logic                           i_is_last,
    input  logic [sip_pkg::W_BYTES-1:0]    i_last_bytes,
    input  logic                           i_out_stall,
    output sip_pkg::t_dp_status            o_status,
    output logic                           o_out_valid,
    output logic [sip_pkg::W_WORD-1:0]     o_hash_low,
    output logic [sip_pkg::W_WORD-1:0]     o_hash_high
);
    import sip_pkg::*;

    t_vstate            r_v;
    t_vstate            n_v;
    logic [W_WORD-1:0]  r_m;
    logic [W_WORD-1:0]  n_m;
    logic [W_TOTAL-1:0] r_total;
    logic [W_TOTAL-1:0] n_total;
    logic               r_open;
    logic               r_last;
    logic [W_WORD-1:0]  r_h0;
    logic [W_WORD-1:0]  r_h1;
    logic               r_out_valid;
    logic [W_WORD-1:0]  r_hash_low;
    logic [W_WORD-1:0]  r_hash_high;

    t_vstate            rnd;
    t_vstate            base;
    t_vstate            start;
    logic [W_WORD-1:0]  fold;
    logic [W_WORD-1:0]  swapped;
    logic [W_WORD-1:0]  k0;
    logic [W_WORD-1:0]  k1;
    logic [W_WORD-1:0]  mask;
    logic [W_TOTAL-1:0] total_base;
    logic               out_free;

    always_comb begin
        rnd  = i_ctl.do_round ? sip_round(r_v) : r_v;
        fold = rnd[0] ^ rnd[1] ^ rnd[2] ^ rnd[3];
        base = rnd;
        if (i_ctl.loop_exit) begin
            case (i_ctl.exit_act)
                EX_ABSORB: begin
                    base[0] = rnd[0] ^ r_m;
                    if (r_last) begin
                        base[2] = rnd[2] ^ (i_cfg.wide ? TWEAK_WIDE : TWEAK_NARROW);
                    end
                end
                EX_FOLD0: begin
                    if (i_cfg.wide) begin
                        base[1] = rnd[1] ^ TWEAK_HALF2;
                    end
                end
                default: begin
                end
            endcase
        end

        // new word: pad a last word with the running length in its top byte
        swapped    = bswap(i_message_word);
        total_base = r_open ? r_total : '0;
        mask       = (W_WORD'(1) << {i_last_bytes, 3'b000}) - W_WORD'(1);
        if (i_is_last) begin
            n_total = total_base + W_TOTAL'(i_last_bytes);
            n_m     = (swapped & mask) | {n_total, {(W_WORD-W_TOTAL){1'b0}}};
        end else begin
            n_total = total_base + W_TOTAL'(8);
            n_m     = swapped;
        end

        k0 = bswap(i_cfg.key_high);
        k1 = bswap(i_cfg.key_low);
        if (r_open) begin
            start = base;
        end else begin
            start[0] = SIP_C0 ^ k0;
            start[1] = SIP_C1 ^ k1 ^ (i_cfg.wide ? TWEAK_WIDE : '0);
            start[2] = SIP_C2 ^ k0;
            start[3] = SIP_C3 ^ k1;
        end
        start[3] = start[3] ^ n_m;

        n_v = i_ctl.accept ? start : base;

        out_free = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_last      <= 1'b0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.accept) begin
                r_open  <= 1'b1;
                r_last  <= i_is_last;
                r_total <= n_total;
            end else if (i_ctl.emit) begin
                r_open  <= 1'b0;
                r_last  <= 1'b0;
                r_total <= '0;
            end
            if (i_ctl.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_v <= n_v;
        if (i_ctl.accept) begin
            r_m <= n_m;
        end
        if (i_ctl.loop_exit && (i_ctl.exit_act == EX_FOLD0)) begin
            r_h0 <= fold;
        end
        if (i_ctl.loop_exit && (i_ctl.exit_act == EX_FOLD1)) begin
            r_h1 <= fold;
        end
        if (i_ctl.emit) begin
            r_hash_low  <= r_h0;
            r_hash_high <= i_cfg.wide ? r_h1 : '0;
        end
    end

    assign o_status.last     = r_last;
    assign o_status.out_free = out_free;
    assign o_out_valid       = r_out_valid;
    assign o_hash_low        = r_hash_low;
    assign o_hash_high       = r_hash_high;

endmodule
